@@ rtl/tfb_pkg.sv @@
`default_nettype none
package tfb_pkg;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_VALUE = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  localparam logic [1:0] CFG_START_BYTE     = 2'd0;
  localparam logic [1:0] CFG_VEHICLE_ID     = 2'd1;
  localparam logic [1:0] CFG_OVERHEAD_BYTES = 2'd2;

  localparam logic [7:0] START_BYTE_RST     = 8'd153;
  localparam logic [7:0] VEHICLE_ID_RST     = 8'd1;
  localparam logic [7:0] OVERHEAD_BYTES_RST = 8'd6;

  localparam int BurstMax = 8;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  message_id;
    logic [7:0]  payload_length;
    logic [63:0] element_value;
    logic [3:0]  element_bytes;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       sequence_error;
    logic       width_error;
    logic       length_error;
  } out_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] vehicle_id;
    logic [7:0] overhead_bytes;
  } cfg_t;

  typedef struct packed {
    logic [BurstMax-1:0][7:0]    data;
    logic [$clog2(BurstMax)-1:0] last_idx;
    logic                        seq_err;
    logic                        wid_err;
    logic                        len_err;
  } burst_t;

endpackage
`default_nettype wire

@@ rtl/tfb_engine.sv @@
`default_nettype none
module tfb_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire tfb_pkg::in_t  in_item,
  input  wire tfb_pkg::cfg_t cfg,
  output tfb_pkg::burst_t    burst,
  output logic               burst_vld
);

  logic [7:0] sum_a_r, sum_a_nxt;
  logic [7:0] sum_b_r, sum_b_nxt;
  logic [7:0] bytes_emitted_r, bytes_emitted_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic       frame_open_r, frame_open_nxt;

  logic [7:0] acc_a;
  logic [7:0] acc_b;
  logic [7:0] flen;
  logic [7:0] emitted_end;
  logic [7:0] cur_byte;
  logic [2:0] sel;
  logic       width_ok;

  always_comb begin
    burst             = '0;
    burst_vld         = 1'b0;
    sum_a_nxt         = sum_a_r;
    sum_b_nxt         = sum_b_r;
    bytes_emitted_nxt = bytes_emitted_r;
    frame_length_nxt  = frame_length_r;
    frame_open_nxt    = frame_open_r;
    acc_a             = sum_a_r;
    acc_b             = sum_b_r;
    flen              = in_item.payload_length + cfg.overhead_bytes;
    emitted_end       = bytes_emitted_r + 8'd2;
    cur_byte          = '0;
    sel               = '0;
    width_ok          = (in_item.element_bytes == 4'd1) || (in_item.element_bytes == 4'd2) ||
                        (in_item.element_bytes == 4'd4) || (in_item.element_bytes == 4'd8);
    case (in_item.mode)
      tfb_pkg::MODE_START: begin
        burst_vld         = 1'b1;
        acc_a             = flen + cfg.vehicle_id;
        acc_b             = flen + acc_a;
        acc_a             = acc_a + in_item.message_id;
        acc_b             = acc_b + acc_a;
        burst.data[0]     = cfg.start_byte;
        burst.data[1]     = flen;
        burst.data[2]     = cfg.vehicle_id;
        burst.data[3]     = in_item.message_id;
        burst.last_idx    = 3'd3;
        burst.seq_err     = frame_open_r;
        sum_a_nxt         = acc_a;
        sum_b_nxt         = acc_b;
        bytes_emitted_nxt = 8'd4;
        frame_length_nxt  = flen;
        frame_open_nxt    = 1'b1;
      end
      tfb_pkg::MODE_VALUE: begin
        burst_vld = 1'b1;
        if (width_ok) begin
          for (int i = 0; i < tfb_pkg::BurstMax; i++) begin
            if (4'(i) < in_item.element_bytes) begin
              sel           = 3'(in_item.element_bytes - 4'(i) - 4'd1);
              cur_byte      = in_item.element_value[{sel, 3'b000} +: 8];
              burst.data[i] = cur_byte;
              acc_a         = acc_a + cur_byte;
              acc_b         = acc_b + acc_a;
            end
          end
          burst.last_idx    = 3'(in_item.element_bytes - 4'd1);
          sum_a_nxt         = acc_a;
          sum_b_nxt         = acc_b;
          bytes_emitted_nxt = bytes_emitted_r + {4'd0, in_item.element_bytes};
        end else begin
          burst.wid_err = 1'b1;
        end
      end
      tfb_pkg::MODE_END: begin
        burst_vld         = 1'b1;
        burst.data[0]     = sum_a_r;
        burst.data[1]     = sum_b_r;
        burst.last_idx    = 3'd1;
        burst.len_err     = (emitted_end != frame_length_r);
        sum_a_nxt         = '0;
        sum_b_nxt         = '0;
        bytes_emitted_nxt = '0;
        frame_length_nxt  = '0;
        frame_open_nxt    = 1'b0;
      end
      default: begin
        burst_vld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_a_r         <= '0;
      sum_b_r         <= '0;
      bytes_emitted_r <= '0;
      frame_length_r  <= '0;
      frame_open_r    <= 1'b0;
    end else if (in_fire) begin
      sum_a_r         <= sum_a_nxt;
      sum_b_r         <= sum_b_nxt;
      bytes_emitted_r <= bytes_emitted_nxt;
      frame_length_r  <= frame_length_nxt;
      frame_open_r    <= frame_open_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tfb_serial.sv @@
`default_nettype none
module tfb_serial (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tfb_pkg::burst_t burst,
  output logic                 full,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output tfb_pkg::out_t        out_data
);

  tfb_pkg::burst_t act_r;
  tfb_pkg::burst_t pend_r;
  logic            act_vld_r;
  logic            pend_vld_r;
  logic [$clog2(tfb_pkg::BurstMax)-1:0] idx_r;
  logic            at_last;
  logic            out_fire;
  logic            act_done;

  assign at_last   = (idx_r == act_r.last_idx);
  assign out_fire  = act_vld_r && !out_stall;
  assign act_done  = !act_vld_r || (out_fire && at_last);
  assign full      = pend_vld_r;
  assign out_valid = act_vld_r;

  always_comb begin
    out_data.out_byte       = act_r.data[idx_r];
    out_data.last           = at_last;
    out_data.sequence_error = act_r.seq_err;
    out_data.width_error    = act_r.wid_err;
    out_data.length_error   = act_r.len_err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      idx_r      <= '0;
    end else if (act_done) begin
      idx_r <= '0;
      if (pend_vld_r) begin
        act_r      <= pend_r;
        act_vld_r  <= 1'b1;
        pend_vld_r <= 1'b0;
      end else if (push) begin
        act_r     <= burst;
        act_vld_r <= 1'b1;
      end else begin
        act_vld_r <= 1'b0;
      end
    end else begin
      if (out_fire) begin
        idx_r <= idx_r + 3'd1;
      end
      if (push) begin
        pend_r     <= burst;
        pend_vld_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/telemetry_frame_builder_top.sv @@
// Telemetry frame builder: turns start, value and end transactions into a
// byte stream with a two-byte running checksum.
// Input channel in_valid/in_stall/in_data carries one transaction; output
// channel out_valid/out_stall/out_data carries one frame byte per transaction.
// A start transaction gives 4 bytes, a value 1, 2, 4 or 8 bytes, a bad width
// 1 flagged byte, an end 2 checksum bytes; mode three gives nothing.
// The serializer registers each burst before offering its first byte.
// Throughput: one byte per cycle on the output while out_stall is low; an
// input transaction of n bytes is sent by the output byte serializer as n
// bytes in turn. One further transaction is buffered behind the one being
// sent, so back-to-back single-byte items flow at one per cycle without stalls.
// Frame state and checksums update at input acceptance.
// Config writes (cfg_we/cfg_index/cfg_wdata) apply at the next edge; write
// them only while idle. Index 3 is ignored.
// Reset (rst_n low, synchronous) restores register defaults, closes any
// frame and drops bytes in flight. When the receiver stalls, the current
// byte holds and in_stall rises once the buffer behind it is occupied.
`default_nettype none
module telemetry_frame_builder_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire tfb_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output tfb_pkg::out_t     out_data,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [7:0]   cfg_wdata
);

  tfb_pkg::cfg_t   cfg_r;
  tfb_pkg::burst_t burst;
  logic            burst_vld;
  logic            in_fire;
  logic            full;

  assign in_stall = full;
  assign in_fire  = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte     <= tfb_pkg::START_BYTE_RST;
      cfg_r.vehicle_id     <= tfb_pkg::VEHICLE_ID_RST;
      cfg_r.overhead_bytes <= tfb_pkg::OVERHEAD_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tfb_pkg::CFG_START_BYTE:     cfg_r.start_byte     <= cfg_wdata;
        tfb_pkg::CFG_VEHICLE_ID:     cfg_r.vehicle_id     <= cfg_wdata;
        tfb_pkg::CFG_OVERHEAD_BYTES: cfg_r.overhead_bytes <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  tfb_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_data),
    .cfg       (cfg_r),
    .burst     (burst),
    .burst_vld (burst_vld)
  );

  tfb_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && burst_vld),
    .burst     (burst),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_width_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.width_error |-> out_data.last && (out_data.out_byte == 8'd0))
    else $error("width error transaction not a single zero byte");

  a_err_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_data.sequence_error, out_data.width_error,
                              out_data.length_error}) <= 1)
    else $error("more than one error flag on a byte");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output or stall active after reset");

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`default_nettype none
module testbench;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 36;

  class frame_byte_tracker;
    logic [7:0] marker;
    logic [7:0] vehicle;
    logic [7:0] overhead;
    logic [7:0] fletch_a;
    logic [7:0] fletch_b;
    logic [7:0] sent_count;
    logic [7:0] declared_len;
    logic       in_frame;
    tfb_pkg::out_t expected_bytes[$];
    int         mismatches;
    int         bytes_seen;

    function new();
      marker = tfb_pkg::START_BYTE_RST;
      vehicle = tfb_pkg::VEHICLE_ID_RST;
      overhead = tfb_pkg::OVERHEAD_BYTES_RST;
      fletch_a = '0;
      fletch_b = '0;
      sent_count = '0;
      declared_len = '0;
      in_frame = 1'b0;
      mismatches = 0;
      bytes_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        tfb_pkg::CFG_START_BYTE:     marker = val;
        tfb_pkg::CFG_VEHICLE_ID:     vehicle = val;
        tfb_pkg::CFG_OVERHEAD_BYTES: overhead = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void add_to_sums(logic [7:0] x);
      fletch_a = fletch_a + x;
      fletch_b = fletch_b + fletch_a;
    endfunction

    function tfb_pkg::out_t make_byte(logic [7:0] b, logic seq, logic wid, logic len);
      tfb_pkg::out_t r;
      r.out_byte = b;
      r.last = 1'b0;
      r.sequence_error = seq;
      r.width_error = wid;
      r.length_error = len;
      return r;
    endfunction

    function void note_item(tfb_pkg::in_t it);
      tfb_pkg::out_t burst[8];
      int          n;
      int          nb;
      logic        seq;
      logic        lerr;
      logic [63:0] v;
      n = 0;
      case (it.mode)
        tfb_pkg::MODE_START: begin
          seq = in_frame;
          declared_len = it.payload_length + overhead;
          fletch_a = declared_len;
          fletch_b = declared_len;
          add_to_sums(vehicle);
          add_to_sums(it.message_id);
          burst[0] = make_byte(marker, seq, 1'b0, 1'b0);
          burst[1] = make_byte(declared_len, seq, 1'b0, 1'b0);
          burst[2] = make_byte(vehicle, seq, 1'b0, 1'b0);
          burst[3] = make_byte(it.message_id, seq, 1'b0, 1'b0);
          n = 4;
          sent_count = 8'd4;
          in_frame = 1'b1;
        end
        tfb_pkg::MODE_VALUE: begin
          nb = int'(it.element_bytes);
          v = it.element_value;
          if (nb == 1 || nb == 2 || nb == 4 || nb == 8) begin
            for (int i = 0; i < nb; i++) begin
              burst[i] = make_byte(v[8*(nb-1-i) +: 8], 1'b0, 1'b0, 1'b0);
              add_to_sums(burst[i].out_byte);
            end
            n = nb;
            sent_count = sent_count + 8'(nb);
          end else begin
            burst[0] = make_byte(8'd0, 1'b0, 1'b1, 1'b0);
            n = 1;
          end
        end
        tfb_pkg::MODE_END: begin
          sent_count = sent_count + 8'd2;
          lerr = (sent_count != declared_len);
          burst[0] = make_byte(fletch_a, 1'b0, 1'b0, lerr);
          burst[1] = make_byte(fletch_b, 1'b0, 1'b0, lerr);
          n = 2;
          fletch_a = '0;
          fletch_b = '0;
          sent_count = '0;
          declared_len = '0;
          in_frame = 1'b0;
        end
        default: ;
      endcase
      if (n > 0) begin
        burst[n-1].last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        expected_bytes.push_back(burst[i]);
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH byte %0d: %s", bytes_seen, msg);
      mismatches++;
    endtask

    task check_byte(tfb_pkg::out_t got);
      tfb_pkg::out_t want;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction %h", got));
      end else begin
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        if (got.sequence_error !== want.sequence_error)
          report_mismatch($sformatf("sequence_error %b, want %b",
                                    got.sequence_error, want.sequence_error));
        if (got.width_error !== want.width_error)
          report_mismatch($sformatf("width_error %b, want %b",
                                    got.width_error, want.width_error));
        if (got.length_error !== want.length_error)
          report_mismatch($sformatf("length_error %b, want %b",
                                    got.length_error, want.length_error));
      end
      bytes_seen++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  tfb_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  tfb_pkg::out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  frame_byte_tracker tracker;
  int burst_left;
  int items_done;
  int cycles;

  telemetry_frame_builder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: stall pattern changes each time its phase counter runs out
  initial begin
    int pattern;
    int phase_cnt;
    pattern = 0;
    phase_cnt = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_cnt == 0) begin
        pattern = $urandom_range(0, 4);
        phase_cnt = 64;
      end
      phase_cnt--;
      case (pattern)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 3) == 0);
        2: out_stall = ($urandom_range(0, 3) != 0);
        3: out_stall = (phase_cnt % 3 == 0);
        default: out_stall = (phase_cnt % 16 < 6);
      endcase
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        tracker.check_byte(out_data);
    end
  end

  function automatic tfb_pkg::in_t make_item(logic [1:0] mode, logic [7:0] msg,
                                             logic [7:0] plen, logic [63:0] val,
                                             logic [3:0] nb);
    tfb_pkg::in_t it;
    it.mode = mode;
    it.message_id = msg;
    it.payload_length = plen;
    it.element_value = val;
    it.element_bytes = nb;
    return it;
  endfunction

  function automatic tfb_pkg::in_t random_item(logic [1:0] mode);
    return make_item(mode, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 249)),
                     {$urandom, $urandom}, 4'($urandom_range(0, 8)));
  endfunction

  task automatic push_item(input tfb_pkg::in_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_item(it);
    burst_left--;
    if (it.mode != MODE_IGNORED) items_done++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic random_frame();
    int   kind;
    int   count;
    int   total;
    int   widths[8];
    int   plen;
    tfb_pkg::in_t it;
    kind = $urandom_range(0, 11);
    count = $urandom_range(0, 6);
    total = 0;
    for (int i = 0; i < count; i++) begin
      widths[i] = 1 << $urandom_range(0, 3);
      total += widths[i];
    end
    // match the declared length to the bytes sent where the field allows it
    plen = (total + 6 - int'(tracker.overhead)) & 255;
    if (plen > 249 || kind == 0) plen = $urandom_range(0, 249);
    if (kind != 4) begin
      it = random_item(tfb_pkg::MODE_START);
      it.payload_length = 8'(plen);
      push_item(it);
    end
    for (int i = 0; i < count; i++) begin
      if (kind == 1 && $urandom_range(0, 2) == 0) begin
        it = random_item(tfb_pkg::MODE_VALUE);
        it.element_bytes = 4'($urandom_range(0, 3) == 0 ? 0 : 3 + $urandom_range(0, 1) * 2);
        if ($urandom_range(0, 1) == 0) it.element_bytes = 4'($urandom_range(6, 7));
        push_item(it);
      end
      if (kind == 2 && $urandom_range(0, 2) == 0) push_item(random_item(MODE_IGNORED));
      it = random_item(tfb_pkg::MODE_VALUE);
      it.element_bytes = 4'(widths[i]);
      push_item(it);
    end
    if (kind != 3) push_item(random_item(tfb_pkg::MODE_END));
  endtask

  task automatic run_phase();
    int target;
    target = items_done + PHASE_ITEMS;
    while (items_done < target) random_frame();
    wait_idle();
  endtask

  initial begin
    tracker = new();
    burst_left = 0;
    items_done = 0;
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = tfb_pkg::CFG_START_BYTE;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    push_item(make_item(tfb_pkg::MODE_VALUE, 8'h00, 8'h00, 64'hFF, 4'd1));
    push_item(make_item(tfb_pkg::MODE_END, 8'hFF, 8'hFF, '1, 4'd8));
    push_item(make_item(tfb_pkg::MODE_START, 8'hFF, 8'd15, '0, 4'd0));
    push_item(make_item(tfb_pkg::MODE_VALUE, 8'h00, 8'h00, '1, 4'd1));
    push_item(make_item(tfb_pkg::MODE_VALUE, 8'h00, 8'h00, '1, 4'd2));
    push_item(make_item(tfb_pkg::MODE_VALUE, 8'h00, 8'h00, 64'h0123_4567_89AB_CDEF, 4'd4));
    push_item(make_item(tfb_pkg::MODE_VALUE, 8'h00, 8'h00, 64'h0123_4567_89AB_CDEF, 4'd8));
    push_item(make_item(tfb_pkg::MODE_END, 8'h00, 8'h00, '0, 4'd0));
    push_item(make_item(tfb_pkg::MODE_START, 8'h00, 8'd0, '1, 4'd8));
    push_item(make_item(tfb_pkg::MODE_START, 8'hA5, 8'd249, '0, 4'd1));
    push_item(make_item(tfb_pkg::MODE_VALUE, 8'h00, 8'h00, '1, 4'd0));
    push_item(make_item(tfb_pkg::MODE_VALUE, 8'h00, 8'h00, '1, 4'd3));
    push_item(make_item(tfb_pkg::MODE_VALUE, 8'h00, 8'h00, '1, 4'd5));
    push_item(make_item(tfb_pkg::MODE_VALUE, 8'h00, 8'h00, '1, 4'd6));
    push_item(make_item(tfb_pkg::MODE_VALUE, 8'h00, 8'h00, '1, 4'd7));
    push_item(make_item(tfb_pkg::MODE_VALUE, 8'hFF, 8'hFF, '0, 4'd8));
    push_item(make_item(MODE_IGNORED, 8'hFF, 8'hFF, '1, 4'd8));
    push_item(make_item(tfb_pkg::MODE_END, 8'h00, 8'h00, '0, 4'd0));
    push_item(make_item(tfb_pkg::MODE_VALUE, 8'h00, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8));
    push_item(make_item(tfb_pkg::MODE_END, 8'h00, 8'h00, '0, 4'd0));
    wait_idle();

    run_phase();
    write_reg(tfb_pkg::CFG_START_BYTE, 8'h00);
    write_reg(tfb_pkg::CFG_VEHICLE_ID, 8'h00);
    write_reg(tfb_pkg::CFG_OVERHEAD_BYTES, 8'h00);
    run_phase();
    write_reg(tfb_pkg::CFG_START_BYTE, 8'hFF);
    write_reg(tfb_pkg::CFG_VEHICLE_ID, 8'hFF);
    write_reg(tfb_pkg::CFG_OVERHEAD_BYTES, 8'hFF);
    run_phase();
    repeat (2) begin
      write_reg(tfb_pkg::CFG_START_BYTE, 8'($urandom_range(0, 255)));
      write_reg(tfb_pkg::CFG_VEHICLE_ID, 8'($urandom_range(0, 255)));
      write_reg(tfb_pkg::CFG_OVERHEAD_BYTES, 8'($urandom_range(0, 255)));
      run_phase();
    end

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/tfb_pkg.sv
rtl/tfb_engine.sv
rtl/tfb_serial.sv
rtl/telemetry_frame_builder_top.sv
tb/sv/testbench.sv
